// ===== design/dda_line_pixel_generator_macros.svh =====
// assertion macros for the dda line pixel generator
`ifndef DDA_LINE_PIXEL_GENERATOR_MACROS_SVH
`define DDA_LINE_PIXEL_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// expression must never hold outside reset
`define DLPG_ASSERT_NEVER(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("dlpg assertion failed");

// same-cycle implication
`define DLPG_ASSERT_IMPLIES(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dlpg assertion failed");

// next-cycle implication
`define DLPG_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dlpg assertion failed");

`else

`define DLPG_ASSERT_NEVER(name, expr)
`define DLPG_ASSERT_IMPLIES(name, ante, cons)
`define DLPG_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== design/dlpg_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and microcode program of the dda line pixel generator
package dlpg_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int PC_BITS = 3;
	typedef logic [PC_BITS-1:0] pc_t;

	// microcode addresses
	localparam pc_t PC_IDLE      = 3'd0;
	localparam pc_t PC_SETUP     = 3'd1;
	localparam pc_t PC_DIV_FIRST = 3'd2;
	localparam pc_t PC_DIV_LOOP  = 3'd3;
	localparam pc_t PC_FINISH    = 3'd4;

	typedef enum logic [1:0] {
		JMP_NEXT   = 2'd0,
		JMP_ALWAYS = 2'd1,
		JMP_IDLE   = 2'd2,
		JMP_LOOP   = 2'd3
	} jmp_t;

	typedef struct packed {
		logic load;
		logic first;
		logic iter;
	} div_ctl_t;

	typedef struct packed {
		logic     accept;
		logic     setup;
		div_ctl_t div;
		logic     finish;
		jmp_t     jmp;
		pc_t      target;
	} ctl_word_t;

	// control store
	function automatic ctl_word_t ucode(pc_t pc);
		ctl_word_t w;
		w = '0;
		unique case (pc)
			PC_IDLE: begin
				w.accept = 1'b1;
				w.jmp    = JMP_IDLE;
				w.target = PC_IDLE;
			end
			PC_SETUP: begin
				w.setup    = 1'b1;
				w.div.load = 1'b1;
				w.jmp      = JMP_NEXT;
			end
			PC_DIV_FIRST: begin
				w.div.first = 1'b1;
				w.jmp       = JMP_NEXT;
			end
			PC_DIV_LOOP: begin
				w.div.iter = 1'b1;
				w.jmp      = JMP_LOOP;
				w.target   = PC_DIV_LOOP;
			end
			PC_FINISH: begin
				w.finish = 1'b1;
				w.jmp    = JMP_ALWAYS;
				w.target = PC_IDLE;
			end
			default: begin
				w.jmp    = JMP_ALWAYS;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== design/dlpg_in_if.sv =====
`timescale 1ns / 1ps
// request channel carrying line loads and pixel advances
interface dlpg_in_if #(
	parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;

	modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== design/dlpg_out_if.sv =====
`timescale 1ns / 1ps
// pixel result channel
interface dlpg_out_if #(
	parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic                  last;

	modport source (output valid, pixel_x, pixel_y, last, input ready);
	modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

// ===== design/dlpg_div.sv =====
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, yields floored signed increment
module dlpg_div #(
	parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dlpg_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  dlpg_pkg::div_ctl_t     ctl,
	input  logic [COORD_BITS-1:0]  mag,
	input  logic                   neg,
	input  logic [COORD_BITS-1:0]  steps,
	output logic [FRAC_BITS+1:0]   inc
);

	logic [COORD_BITS-1:0] rem_q;
	logic [FRAC_BITS:0]    quo_q;
	logic                  neg_q;

	logic [COORD_BITS:0]   rem_sh;
	logic [COORD_BITS:0]   rem_diff;
	logic                  rem_ge;
	logic                  first_ge;
	logic [FRAC_BITS+1:0]  quo_ext;
	logic [FRAC_BITS+1:0]  quo_up;

	assign rem_sh   = {rem_q, 1'b0};
	assign rem_diff = rem_sh - {1'b0, steps};
	assign rem_ge   = rem_sh >= {1'b0, steps};
	assign first_ge = rem_q >= steps;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= mag;
			quo_q <= '0;
			neg_q <= neg;
		end else if (ctl.first) begin
			// magnitude never exceeds steps, so at most one subtraction here
			if (first_ge) begin
				rem_q <= rem_q - steps;
			end
			quo_q <= (FRAC_BITS+1)'(first_ge);
		end else if (ctl.iter) begin
			rem_q <= rem_ge ? rem_diff[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
			quo_q <= {quo_q[FRAC_BITS-1:0], rem_ge};
		end
	end

	// negative deltas round toward minus infinity
	assign quo_ext = {1'b0, quo_q};
	assign quo_up  = quo_ext + (FRAC_BITS+2)'(rem_q != '0);
	assign inc     = neg_q ? (~quo_up + (FRAC_BITS+2)'(1)) : quo_ext;

endmodule

// ===== design/dda_line_pixel_generator.sv =====
`timescale 1ns / 1ps
// dda line rasterizer top level: microcoded load sequence and pixel stepping
`include "dda_line_pixel_generator_macros.svh"

// A load request (action 0) takes the two endpoints and keeps the block busy from
// its own accept cycle on: one setup step, then a restoring divide that produces
// one increment bit per cycle for x and y together, then a step that commits the
// increments. During that time no request is accepted. An advance request
// (action 1), while a line is active, places one pixel in the output register, so
// pixels stream at one per cycle as long as the consumer takes them. A line of N
// steps gives N pixels from the start point up to but not including the end
// point, the last one flagged; a zero-length line gives its start pixel once. An
// advance with no active line is accepted and gives nothing.
module dda_line_pixel_generator #(
	parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dlpg_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dlpg_in_if.sink     in_ch,
	dlpg_out_if.source  out_ch
);

	localparam int ACC_BITS  = COORD_BITS + FRAC_BITS;
	localparam int INC_BITS  = FRAC_BITS + 2;
	localparam int STEP_BITS = COORD_BITS + 1;
	localparam int CNT_BITS  = $clog2(FRAC_BITS + 1);

	dlpg_pkg::pc_t       pc_q;
	dlpg_pkg::pc_t       pc_next;
	dlpg_pkg::ctl_word_t ctl;
	logic                jump;

	logic [CNT_BITS-1:0] cnt_q;

	logic [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
	logic [COORD_BITS-1:0] steps_q;

	logic [ACC_BITS-1:0]  x_acc_q, y_acc_q;
	logic [INC_BITS-1:0]  x_inc_q, y_inc_q;
	logic [STEP_BITS-1:0] steps_left_q;
	logic                 active_q;

	logic                  out_valid_q;
	logic [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
	logic                  last_q;

	logic in_acc;
	logic load_acc;
	logic emit;

	logic [COORD_BITS:0]   dx, dy;
	logic [COORD_BITS:0]   dx_abs, dy_abs;
	logic [COORD_BITS-1:0] adx, ady, steps_max;

	logic [INC_BITS-1:0] x_div_inc, y_div_inc;
	logic                steps_zero;

	logic [ACC_BITS-1:0] x_inc_ext, y_inc_ext;
	logic [ACC_BITS-1:0] x_ceil, y_ceil;

	// sequencer
	assign ctl = dlpg_pkg::ucode(pc_q);

	assign in_ch.ready = ctl.accept && (!out_valid_q || out_ch.ready);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign load_acc    = in_acc && !in_ch.action;
	assign emit        = in_acc && in_ch.action && active_q;

	always_comb begin
		case (ctl.jmp)
			dlpg_pkg::JMP_ALWAYS: jump = 1'b1;
			dlpg_pkg::JMP_IDLE:   jump = !load_acc;
			dlpg_pkg::JMP_LOOP:   jump = cnt_q != CNT_BITS'(1);
			default:              jump = 1'b0;
		endcase
		pc_next = jump ? ctl.target : pc_q + dlpg_pkg::pc_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= dlpg_pkg::PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			cnt_q <= CNT_BITS'(FRAC_BITS);
		end else if (ctl.div.iter) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

	// setup: deltas, magnitudes and step count
	assign dx        = {1'b0, ex_q} - {1'b0, sx_q};
	assign dy        = {1'b0, ey_q} - {1'b0, sy_q};
	assign dx_abs    = dx[COORD_BITS] ? (~dx + (COORD_BITS+1)'(1)) : dx;
	assign dy_abs    = dy[COORD_BITS] ? (~dy + (COORD_BITS+1)'(1)) : dy;
	assign adx       = dx_abs[COORD_BITS-1:0];
	assign ady       = dy_abs[COORD_BITS-1:0];
	assign steps_max = (adx > ady) ? adx : ady;

	// divisor is taken from the step count registered at setup
	dlpg_div #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div_x (
		.clk   (clk),
		.ctl   (ctl.div),
		.mag   (adx),
		.neg   (dx[COORD_BITS]),
		.steps (steps_q),
		.inc   (x_div_inc)
	);

	dlpg_div #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div_y (
		.clk   (clk),
		.ctl   (ctl.div),
		.mag   (ady),
		.neg   (dy[COORD_BITS]),
		.steps (steps_q),
		.inc   (y_div_inc)
	);

	assign steps_zero = steps_q == '0;

	// stepping datapath
	assign x_inc_ext = {{(ACC_BITS-INC_BITS){x_inc_q[INC_BITS-1]}}, x_inc_q};
	assign y_inc_ext = {{(ACC_BITS-INC_BITS){y_inc_q[INC_BITS-1]}}, y_inc_q};
	assign x_ceil    = x_acc_q + ACC_BITS'((1 << FRAC_BITS) - 1);
	assign y_ceil    = y_acc_q + ACC_BITS'((1 << FRAC_BITS) - 1);

	always_ff @(posedge clk) begin
		if (load_acc) begin
			sx_q <= in_ch.start_x;
			sy_q <= in_ch.start_y;
			ex_q <= in_ch.end_x;
			ey_q <= in_ch.end_y;
		end
		if (ctl.setup) begin
			steps_q <= steps_max;
			x_acc_q <= {sx_q, {FRAC_BITS{1'b0}}};
			y_acc_q <= {sy_q, {FRAC_BITS{1'b0}}};
		end else if (emit) begin
			x_acc_q <= x_acc_q + x_inc_ext;
			y_acc_q <= y_acc_q + y_inc_ext;
		end
		if (ctl.finish) begin
			x_inc_q <= steps_zero ? '0 : x_div_inc;
			y_inc_q <= steps_zero ? '0 : y_div_inc;
		end
		if (emit) begin
			pixel_x_q <= x_ceil[ACC_BITS-1:FRAC_BITS];
			pixel_y_q <= y_ceil[ACC_BITS-1:FRAC_BITS];
			last_q    <= steps_left_q == STEP_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_left_q <= '0;
			active_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctl.finish) begin
				// zero-length line still gives its start pixel
				steps_left_q <= steps_zero ? STEP_BITS'(1) : {1'b0, steps_q};
				active_q     <= 1'b1;
			end else if (emit) begin
				steps_left_q <= steps_left_q - STEP_BITS'(1);
				if (steps_left_q == STEP_BITS'(1)) begin
					active_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.pixel_x = pixel_x_q;
	assign out_ch.pixel_y = pixel_y_q;
	assign out_ch.last    = last_q;

	`DLPG_ASSERT_NEVER(a_active_has_steps, active_q && steps_left_q == '0)
	`DLPG_ASSERT_IMPLIES(a_loop_cnt_live, pc_q == dlpg_pkg::PC_DIV_LOOP, cnt_q != '0)
	`DLPG_ASSERT_NEXT(a_emit_valid, emit, out_valid_q && (last_q == !active_q))

endmodule
